FILE: design/bma_pkg.sv
// shared types and constants for the boxcar moving average block
// no dependencies
`default_nettype none

package bma_pkg;

   localparam int DATA_W       = 32;
   localparam int SUM_W        = 38;
   localparam int ALU_W        = SUM_W + 1;
   localparam int SEEN_W       = 6;
   localparam int NARROW_LIMIT = 3;
   localparam int CNT_W        = $clog2(SUM_W);

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_READ = 9'b000000010,
      ST_ADD  = 9'b000000100,
      ST_SUB  = 9'b000001000,
      ST_ABS  = 9'b000010000,
      ST_DIV  = 9'b000100000,
      ST_SIGN = 9'b001000000,
      ST_EMIT = 9'b010000000,
      ST_NEXT = 9'b100000000
   } state_type;

endpackage

`default_nettype wire

FILE: design/boxcar_moving_average.sv
// centered boxcar moving average over a streamed spectrum
// uses bma_pkg; window samples live in a circular buffer memory
`default_nettype none

// a narrow window (below 3) passes a sample through the result register and the EMIT state into the
// output register; the next sample is not taken until that beat is loaded
// a normal sample steps through read, add, subtract and next; each average it releases adds the abs,
// divide, sign and emit states, with the one-bit-per-cycle 38-step divider on the shared 39-bit adder
// a last sample flushes up to half+1 averages; input is held off until the last of them is
// loaded into the output register
// synchronous active-high reset clears the window, sum, counts and the width register; the window
// memory itself is not swept: a fill count marks unwritten entries, which read as zero

module boxcar_moving_average #(
   parameter int MAX_WIDTH = 63
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // csr_wr_data: window_width
   input  wire logic                        csr_wr_en,
   input  wire logic [5:0]                  csr_wr_data,
   // req_tdata: sample [31:0]
   input  wire logic                        req_tvalid,
   output      logic                        req_tready,
   input  wire logic [bma_pkg::DATA_W-1:0]  req_tdata,
   input  wire logic                        req_tlast,
   // rsp_tdata: average [31:0]
   output      logic                        rsp_tvalid,
   input  wire logic                        rsp_tready,
   output      logic [bma_pkg::DATA_W-1:0]  rsp_tdata,
   output      logic                        rsp_tlast
);
   import bma_pkg::*;

   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int AW  = $clog2(MAX_WIDTH);
   localparam int CAP = (MAX_WIDTH % 2 == 0) ? MAX_WIDTH - 1 : MAX_WIDTH;

   state_type               state_ff, state_in;
   logic [5:0]              cfg_ff, cfg_in;
   logic [WW-1:0]           w_ff, w_in;
   logic [WW-1:0]           half_ff, half_in;
   logic [WW-1:0]           f_ff, f_in;
   logic [WW-1:0]           fill_ff, fill_in;
   logic [AW-1:0]           head_ff, head_in;
   logic [SEEN_W-1:0]       seen_ff, seen_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [SUM_W-1:0]        q_ff, q_in;
   logic [WW-1:0]           rem_ff, rem_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    neg_ff, neg_in;
   logic                    last_ff, last_in;
   logic                    narrow_ff, narrow_in;
   logic                    out_ok_ff, out_ok_in;
   logic [DATA_W-1:0]       push_ff, push_in;
   logic [DATA_W-1:0]       res_ff, res_in;
   logic                    res_last_ff, res_last_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]       rsp_data_ff, rsp_data_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [DATA_W-1:0]       mem [MAX_WIDTH];
   logic [DATA_W-1:0]       mem_q_ff;
   logic                    mem_en;
   logic [AW-1:0]           rd_addr, wr_addr;

   logic [ALU_W-1:0]        alu_a, alu_b, alu_y;
   logic                    alu_sub;

   logic [8:0]              w_wide, w_odd, wm1, head_x, rd_x;
   logic [WW-1:0]           w_eff;
   logic                    accept, out_free, want_out;
   logic [DATA_W-1:0]       outgoing;
   logic [WW:0]             rem_shift;

   // shared adder / subtractor
   assign alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // even widths round up, then clamp to the largest odd width the store holds
   always_comb begin
      w_odd  = 9'(cfg_ff) + (cfg_ff[0] ? 9'd0 : 9'd1);
      w_wide = (w_odd > 9'(CAP)) ? 9'(CAP) : w_odd;
      w_eff  = w_wide[WW-1:0];
   end

   // outgoing entry is w-1 pushes older than the newest one
   always_comb begin
      wm1     = 9'(w_ff) - 9'd1;
      head_x  = 9'(head_ff);
      rd_x    = (head_x >= wm1) ? head_x - wm1 : head_x + 9'(MAX_WIDTH) - wm1;
      rd_addr = rd_x[AW-1:0];
      wr_addr = (head_ff == AW'(MAX_WIDTH - 1)) ? '0 : head_ff + 1'b1;
   end

   assign outgoing  = out_ok_ff ? mem_q_ff : '0;
   assign rem_shift = {rem_ff, q_ff[SUM_W-1]};
   assign want_out  = (9'(seen_ff) + 9'(f_ff)) > 9'(half_ff);
   assign mem_en    = (state_ff == ST_READ);

   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      case (state_ff)
         ST_ADD: begin
            alu_a = ALU_W'($signed(sum_ff));
            alu_b = ALU_W'($signed(push_ff));
         end
         ST_SUB: begin
            alu_a   = ALU_W'($signed(sum_ff));
            alu_b   = ALU_W'($signed(outgoing));
            alu_sub = 1'b1;
         end
         ST_ABS: begin
            alu_b   = ALU_W'($signed(sum_ff));
            alu_sub = 1'b1;
         end
         ST_DIV: begin
            alu_a   = ALU_W'(rem_shift);
            alu_b   = ALU_W'(w_ff);
            alu_sub = 1'b1;
         end
         ST_SIGN: begin
            alu_b   = ALU_W'(q_ff);
            alu_sub = 1'b1;
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   always_comb begin
      logic [SUM_W-1:0] sq;
      sq           = '0;
      state_in     = state_ff;
      cfg_in       = csr_wr_en ? csr_wr_data : cfg_ff;
      w_in         = w_ff;
      half_in      = half_ff;
      f_in         = f_ff;
      fill_in      = fill_ff;
      head_in      = head_ff;
      seen_in      = seen_ff;
      sum_in       = sum_ff;
      q_in         = q_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      last_in      = last_ff;
      narrow_in    = narrow_ff;
      out_ok_in    = out_ok_ff;
      push_in      = push_ff;
      res_in       = res_ff;
      res_last_in  = res_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in = req_tlast;
               if (w_wide < 9'(NARROW_LIMIT)) begin
                  narrow_in   = 1'b1;
                  res_in      = req_tdata;
                  res_last_in = req_tlast;
                  if (req_tlast) begin
                     sum_in  = '0;
                     seen_in = '0;
                     fill_in = '0;
                  end
                  state_in = ST_EMIT;
               end else begin
                  narrow_in = 1'b0;
                  w_in      = w_eff;
                  half_in   = w_eff >> 1;
                  f_in      = '0;
                  push_in   = req_tdata;
                  if (seen_ff != '1) begin
                     seen_in = seen_ff + 1'b1;
                  end
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            out_ok_in = (fill_ff >= w_ff);
            head_in   = wr_addr;
            if (fill_ff != WW'(MAX_WIDTH)) begin
               fill_in = fill_ff + 1'b1;
            end
            state_in = ST_ADD;
         end
         ST_ADD: begin
            sum_in   = alu_y[SUM_W-1:0];
            state_in = ST_SUB;
         end
         ST_SUB: begin
            sum_in   = alu_y[SUM_W-1:0];
            state_in = want_out ? ST_ABS : ST_NEXT;
         end
         ST_ABS: begin
            neg_in   = sum_ff[SUM_W-1];
            q_in     = sum_ff[SUM_W-1] ? alu_y[SUM_W-1:0] : sum_ff;
            rem_in   = '0;
            cnt_in   = CNT_W'(SUM_W - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // restoring step: keep the trial difference when it does not go negative
            rem_in = alu_y[ALU_W-1] ? rem_shift[WW-1:0] : alu_y[WW-1:0];
            q_in   = {q_ff[SUM_W-2:0], !alu_y[ALU_W-1]};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            sq = neg_ff ? alu_y[SUM_W-1:0] : q_ff;
            // saturate to the 32-bit signed range
            if (sq[SUM_W-1:DATA_W-1] == '0 || sq[SUM_W-1:DATA_W-1] == '1) begin
               res_in = sq[DATA_W-1:0];
            end else begin
               res_in = {sq[SUM_W-1], {(DATA_W - 1){!sq[SUM_W-1]}}};
            end
            res_last_in = last_ff && (f_ff == half_ff);
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               rsp_last_in  = res_last_ff;
               state_in     = narrow_ff ? ST_IDLE : ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (last_ff && (f_ff != half_ff)) begin
               // flush: push a zero beyond the end of the spectrum
               f_in     = f_ff + 1'b1;
               push_in  = '0;
               state_in = ST_READ;
            end else begin
               if (last_ff) begin
                  sum_in  = '0;
                  seen_in = '0;
                  fill_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_ff       <= '0;
         f_ff         <= '0;
         fill_ff      <= '0;
         head_ff      <= '0;
         seen_ff      <= '0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         last_ff      <= 1'b0;
         narrow_ff    <= 1'b0;
         out_ok_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         f_ff         <= f_in;
         fill_ff      <= fill_in;
         head_ff      <= head_in;
         seen_ff      <= seen_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         narrow_ff    <= narrow_in;
         out_ok_ff    <= out_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      w_ff        <= w_in;
      half_ff     <= half_in;
      q_ff        <= q_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      push_ff     <= push_in;
      res_ff      <= res_in;
      res_last_ff <= res_last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // window buffer: read-first, so a full-width window sees the entry being replaced
   always_ff @(posedge clock) begin
      if (mem_en) begin
         mem[wr_addr] <= push_ff;
         mem_q_ff     <= mem[rd_addr];
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= WW'(MAX_WIDTH))
      else $error("fill count beyond window depth");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < w_ff))
      else $error("divider remainder not below divisor");

   a_flush_bound: assert property (@(posedge clock) disable iff (reset)
      !narrow_ff && (state_ff != ST_IDLE) |-> (f_ff <= half_ff))
      else $error("flush index past half width");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) && out_free |=> rsp_valid_ff && (state_ff != ST_EMIT))
      else $error("result beat not loaded");

   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ABS) |=> (state_ff == ST_DIV) && (cnt_ff == CNT_W'(SUM_W - 1)))
      else $error("divider not started with full count");

endmodule

`default_nettype wire
